// ----- hdl/tdrr_pkg.sv -----
// Shared types and constants for the tick delay round-robin scheduler.
`timescale 1ns / 1ps

package tdrr_pkg;

  localparam int TICK_W = 32;
  localparam int TASK_ID_W = 3;
  localparam int MASK_W = 5;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_DELAY = 1'b1;

  typedef struct packed {
    logic              op;
    logic [TICK_W-1:0] delay_ticks;
  } item_t;

  typedef struct packed {
    logic [TASK_ID_W-1:0] running_task;
    logic [TICK_W-1:0]    tick_now;
    logic [MASK_W-1:0]    ready_mask;
  } result_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic pick;
  } dp_cmd_t;

endpackage

// ----- hdl/tdrr_ctrl.sv -----
// Sequencing state machine for the scheduler: capture, execute, pick.
`timescale 1ns / 1ps

module tdrr_ctrl import tdrr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  output logic    result_valid,
  input  logic    result_stall,
  output dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_PICK = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   load_ok;
  logic   accept;

  assign load_ok    = !result_valid || !result_stall;
  assign item_stall = !((state == ST_IDLE) || ((state == ST_PICK) && load_ok));
  assign accept     = item_valid && !item_stall;

  assign cmd.capture = accept;
  assign cmd.exec    = (state == ST_EXEC);
  assign cmd.pick    = (state == ST_PICK) && load_ok;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_PICK;
      end
      ST_PICK: begin
        if (load_ok) begin
          state_next = accept ? ST_EXEC : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.pick) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // an accepted word always goes straight to execution
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC))
    else $error("accepted word did not enter execution");

  // execution is always followed by the pick
  a_exec_pick: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |=> (state == ST_PICK))
    else $error("execution not followed by pick");

  // a new result only appears out of the pick state
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_PICK))
    else $error("result appeared without a pick");

endmodule

// ----- hdl/tdrr_dp.sv -----
// Scheduler datapath: tick counter, block flags, wake times, round-robin pick.
`timescale 1ns / 1ps

module tdrr_dp import tdrr_pkg::*; #(
  parameter int TASKS = 5
) (
  input  logic    clk,
  input  logic    rst,
  input  dp_cmd_t cmd,
  input  item_t   item,
  output result_t result
);

  localparam int SW = $clog2(TASKS);

  logic [TICK_W-1:0] tick_counter;
  logic [SW-1:0]     current_slot;
  logic [TASKS-1:0]  blocked;
  logic [TICK_W-1:0] wake_time [TASKS];
  item_t             item_q;

  logic [TICK_W-1:0]    tick_inc;
  logic [TASKS-1:0]     rdy_user;
  logic [2*TASKS-1:0]   rdy_dbl;
  logic [2*TASKS-1:0]   rot_full;
  logic [TASKS-1:0]     rot;
  logic [SW:0]          shamt;
  logic [SW:0]          pos_sum;
  logic [SW:0]          pos_wrap;
  logic [SW-1:0]        offset;
  logic                 found;
  logic [SW-1:0]        pick_slot;
  logic [SW+2:0]        slot_ext;
  logic [TASKS+4:0]     mask_ext;

  assign tick_inc = tick_counter + 32'd1;

  // rotate the user-ready vector so the slot after the running one is bit 0
  assign rdy_user = ~blocked & ~TASKS'(1);
  assign rdy_dbl  = {rdy_user, rdy_user};
  assign shamt    = {1'b0, current_slot} + (SW+1)'(1);
  assign rot_full = rdy_dbl >> shamt;
  assign rot      = rot_full[TASKS-1:0];

  always_comb begin
    found  = 1'b0;
    offset = '0;
    for (int k = TASKS - 1; k >= 0; k--) begin
      if (rot[k]) begin
        found  = 1'b1;
        offset = SW'(k);
      end
    end
  end

  assign pos_sum   = shamt + {1'b0, offset};
  assign pos_wrap  = (pos_sum >= (SW+1)'(TASKS)) ? pos_sum - (SW+1)'(TASKS) : pos_sum;
  assign pick_slot = found ? pos_wrap[SW-1:0] : '0;

  assign slot_ext = {3'b000, pick_slot};
  assign mask_ext = {5'b00000, ~blocked};

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter <= '0;
      current_slot <= SW'(1);
      blocked      <= '0;
    end else begin
      if (cmd.exec) begin
        if (item_q.op == OP_TICK) begin
          tick_counter <= tick_inc;
          for (int i = 1; i < TASKS; i++) begin
            if (blocked[i] && (wake_time[i] == tick_inc)) begin
              blocked[i] <= 1'b0;
            end
          end
        end else if (current_slot != '0) begin
          blocked[current_slot] <= 1'b1;
        end
      end
      if (cmd.pick) begin
        current_slot <= pick_slot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item;
    end
    if (cmd.exec && (item_q.op == OP_DELAY) && (current_slot != '0)) begin
      wake_time[current_slot] <= tick_counter + item_q.delay_ticks;
    end
    if (cmd.pick) begin
      result.running_task <= slot_ext[TASK_ID_W-1:0];
      result.tick_now     <= tick_counter;
      result.ready_mask   <= mask_ext[MASK_W-1:0];
    end
  end

endmodule

// ----- hdl/tick_delay_round_robin_scheduler.sv -----
// Top level of the tick delay round-robin task scheduler.
`timescale 1ns / 1ps
//
// Usage:
//   item channel (item_valid / item_stall / item): one word per event,
//   op = tick advances the 32-bit tick counter and wakes every blocked task
//   whose wake time equals the new count; op = delay blocks the running
//   user task until tick + delay_ticks (ignored while idle runs).
//   result channel (result_valid / result_stall / result): one word per
//   item, carrying the slot picked to run next, the tick count and the
//   ready mask of slots 0..4. Slot 0 is the idle task and is always ready.
// Flow: an accepted item is executed, then the round-robin pick loads the
//   result register; an item is not taken while the previous one executes,
//   and the next item is taken in the same cycle as the pick.
// Reset: tick counter cleared, all tasks ready, slot 1 running, no result.
// Stall: a finished result holds in the output register while
//   result_stall is high; one more item can be taken meanwhile and runs
//   up to its pick, then waits until the register frees.
//
module tick_delay_round_robin_scheduler import tdrr_pkg::*; #(
  parameter int TASKS = 5
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  dp_cmd_t cmd;

  // control: sequences each word and owns the result valid flag
  tdrr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd)
  );

  // datapath: scheduler state and the round-robin pick
  tdrr_dp #(
    .TASKS (TASKS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .result (result)
  );

endmodule
